// ===== rtl/sft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_pkg: shared types and constants of the SPI slave frame transmitter
// Phase codes, command codes, ring and frame geometry, state and beat layouts.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int FRAME_BYTES   = 8192;
  localparam int RING_SLOTS    = 4;
  localparam int SLOT_W        = $clog2(RING_SLOTS);
  localparam int HEAD_W        = SLOT_W + 1;
  localparam int OFFSET_W      = $clog2(FRAME_BYTES);
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_W         = $clog2(BITS_PER_BYTE);
  localparam int CNT_W         = 32;
  localparam int PHASE_W       = 3;
  localparam int ACTION_W      = 2;

  localparam logic [OFFSET_W-1:0] LAST_BYTE = OFFSET_W'(FRAME_BYTES - 1);

  // phase codes
  localparam logic [PHASE_W-1:0] PH_STOP          = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT_CS_LOW   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT_CLK_HIGH = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT_CLK_LOW  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WAIT_FRAME    = 3'd4;

  // command codes carried on s_tuser
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 120;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [BIT_W-1:0]    bit_pos;
    logic [OFFSET_W-1:0] byte_pos;
    logic [HEAD_W-1:0]   head;
    logic [CNT_W-1:0]    sent;
    logic [CNT_W-1:0]    missed;
    logic [CNT_W-1:0]    glitches;
    logic                miso;
  } state_t;

  typedef struct packed {
    logic frame_done;
    logic stop_done;
  } event_t;

endpackage

// ===== rtl/spi_slave_frame_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_slave_frame_transmitter: SPI mode 0 slave sending frames from a ring
// Shifts frame bytes out on MISO, LSB first, and tracks ring and error counts.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one beat per pin sample or command. s_tuser carries
//   the command (sample, start, stop); s_tdata carries the sampled chip select
//   and SPI clock, the producer ring counter and the frame byte at the slot and
//   offset named by the previous result.
//   The master side returns exactly one result beat per input beat: MISO
//   level, ring slot, byte offset, mode, the three wrapping counters and the
//   stop flag; m_tlast marks the beat on which a frame completed.
//   A result is registered and appears on the master side the cycle after
//   its input beat is accepted. Throughput is one beat per cycle unless the
//   receiver stalls, set by the single output register holding each beat's update.
//   While the receiver stalls, the result register holds its beat and
//   s_tready stays low until that beat is taken; it is taken and refilled in
//   the same cycle, so no bubble appears.
//   Reset stops the block: mode stopped, ring head, positions, MISO and all
//   counters cleared, no result pending.
// ----------------------------------------------------------------------------
module spi_slave_frame_transmitter #(
  parameter int FRAME_BYTES = sft_pkg::FRAME_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] cs_level, [1] clk_level, [4:2] queue_tail, [12:5] data_byte
  input  logic [sft_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] action
  input  logic [sft_pkg::ACTION_W-1:0]   s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] miso, [2:1] read_slot, [15:3] read_offset, [18:16] mode,
  // [50:19] frames_sent, [82:51] frames_missed, [114:83] cs_glitches,
  // [115] stop_done
  output logic [sft_pkg::OUT_DATA_W-1:0] m_tdata,
  // frame_done
  output logic                           m_tlast
);
  import sft_pkg::*;

  state_t st;
  state_t st_next;
  event_t evt;
  event_t evt_q;
  logic   accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  sft_step #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_step (
    .cur        (st),
    .action     (s_tuser),
    .cs_level   (s_tdata[0]),
    .clk_level  (s_tdata[1]),
    .queue_tail (s_tdata[4:2]),
    .data_byte  (s_tdata[12:5]),
    .nxt        (st_next),
    .evt        (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      // all-zero state is mode stopped
      st       <= '0;
      evt_q    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        st    <= st_next;
        evt_q <= evt;
      end
      if (accept) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {4'b0, evt_q.stop_done, st.glitches, st.missed, st.sent,
                    st.phase, st.byte_pos, st.head[SLOT_W-1:0], st.miso};
  assign m_tlast = evt_q.frame_done;

  // stop and frame completion come from exclusive branches
  a_evt_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && m_tdata[115]))
    else $error("frame_done and stop_done in one beat");

  a_stop_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[115]) |-> (m_tdata[18:16] == PH_STOP))
    else $error("stop_done without stopped mode");

  a_done_offset: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[15:3] == '0))
    else $error("frame_done with nonzero offset");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == ACT_START) |=>
      (st.sent == '0 && st.missed == '0 && st.glitches == '0))
    else $error("start did not clear counters");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(st))
    else $error("state changed without an accepted beat");

endmodule

// ===== rtl/sft_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_step: next-state logic of the SPI slave frame transmitter
// Works out the state and event flags that follow one beat.
// ----------------------------------------------------------------------------
module sft_step #(
  parameter int FRAME_BYTES = sft_pkg::FRAME_BYTES
) (
  input  sft_pkg::state_t                 cur,
  input  logic [sft_pkg::ACTION_W-1:0]    action,
  input  logic                            cs_level,
  input  logic                            clk_level,
  input  logic [sft_pkg::HEAD_W-1:0]      queue_tail,
  input  logic [7:0]                      data_byte,
  output sft_pkg::state_t                 nxt,
  output sft_pkg::event_t                 evt
);
  import sft_pkg::*;

  logic ring_ready;
  logic last_bit;
  logic last_byte;
  logic [HEAD_W-1:0] head_inc;

  assign ring_ready = (queue_tail != cur.head);
  assign last_bit   = (cur.bit_pos == BIT_W'(BITS_PER_BYTE - 1));
  assign last_byte  = (cur.byte_pos == OFFSET_W'(FRAME_BYTES - 1));
  assign head_inc   = cur.head + HEAD_W'(1);

  always_comb begin
    nxt = cur;
    evt = '0;
    case (action)
      ACT_STOP: begin
        nxt.phase     = PH_STOP;
        evt.stop_done = 1'b1;
      end
      ACT_START: begin
        nxt.sent     = '0;
        nxt.missed   = '0;
        nxt.glitches = '0;
        nxt.phase    = PH_WAIT_FRAME;
        if (ring_ready) begin
          nxt.byte_pos = '0;
          nxt.bit_pos  = '0;
          nxt.phase    = PH_WAIT_CS_LOW;
        end
      end
      default: begin
        case (cur.phase)
          PH_WAIT_FRAME: begin
            if (ring_ready) begin
              nxt.byte_pos = '0;
              nxt.bit_pos  = '0;
              nxt.phase    = PH_WAIT_CS_LOW;
            end
          end
          PH_WAIT_CS_LOW: begin
            if (!cs_level) nxt.phase = PH_WAIT_CLK_LOW;
          end
          PH_WAIT_CLK_LOW: begin
            if (cs_level) begin
              nxt.glitches = cur.glitches + CNT_W'(1);
              nxt.phase    = PH_WAIT_CS_LOW;
            end else if (!clk_level) begin
              nxt.phase = PH_WAIT_CLK_HIGH;
            end
          end
          PH_WAIT_CLK_HIGH: begin
            if (cs_level) begin
              nxt.phase = PH_WAIT_CS_LOW;
            end else if (clk_level) begin
              // rising SPI clock: shift out the next bit, LSB first
              nxt.miso    = data_byte[cur.bit_pos];
              nxt.phase   = PH_WAIT_CLK_LOW;
              nxt.bit_pos = cur.bit_pos + BIT_W'(1);
              if (last_bit) begin
                nxt.byte_pos = cur.byte_pos + OFFSET_W'(1);
                if (last_byte) begin
                  nxt.sent       = cur.sent + CNT_W'(1);
                  evt.frame_done = 1'b1;
                  nxt.head       = head_inc;
                  nxt.byte_pos   = '0;
                  // underrun: park until software refills the ring
                  if (queue_tail == head_inc) begin
                    nxt.missed = cur.missed + CNT_W'(1);
                    nxt.phase  = PH_WAIT_FRAME;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
    endcase
  end

endmodule

// ===== tb/sv/spi_slave_frame_transmitter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_slave_frame_transmitter_test: self-checking bench for the SPI frame sender
// Feeds pin samples and start/stop commands, predicts every result beat with
// an in-bench copy of the sender state, and checks each field of each beat.
// Covers directed corner cases, a run of whole bytes shifted out back to back,
// a long receiver hold-off and random session-shaped traffic with idling.
// ----------------------------------------------------------------------------
module spi_slave_frame_transmitter_test;
  import sft_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1400;
  localparam int STREAM_BITS  = 8 * BITS_PER_BYTE;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // one result beat: m_tdata fields from bit 0 up, frame_done on top
  typedef struct packed {
    logic                frame_done;
    logic                stop_done;
    logic [CNT_W-1:0]    glitches;
    logic [CNT_W-1:0]    missed;
    logic [CNT_W-1:0]    sent;
    logic [PHASE_W-1:0]  mode;
    logic [OFFSET_W-1:0] offset;
    logic [SLOT_W-1:0]   slot;
    logic                miso;
  } tx_status_t;

  localparam int STATUS_W = $bits(tx_status_t) - 1;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [ACTION_W-1:0]   s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // predicted sender state
  logic [PHASE_W-1:0]  tx_phase   = PH_STOP;
  logic [BIT_W-1:0]    bit_idx    = '0;
  logic [OFFSET_W-1:0] byte_idx   = '0;
  logic [HEAD_W-1:0]   ring_head  = '0;
  logic [CNT_W-1:0]    sent_cnt   = '0;
  logic [CNT_W-1:0]    missed_cnt = '0;
  logic [CNT_W-1:0]    glitch_cnt = '0;
  logic                miso_bit   = 1'b0;

  tx_status_t  expected_status[$];
  int          fail_count = 0;
  bit          idle_on    = 1'b1;
  int          hold_left  = 0;
  int unsigned cycle_count = 0;

  spi_slave_frame_transmitter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // advance the predicted state by one accepted beat and return its result
  function automatic tx_status_t advance_transmitter(
      input logic [ACTION_W-1:0]      act,
      input logic                     cs,
      input logic                     sck,
      input logic [HEAD_W-1:0]        tail,
      input logic [BITS_PER_BYTE-1:0] data);
    tx_status_t r;
    r = '0;
    if (act == ACT_STOP) begin
      tx_phase = PH_STOP;
      r.stop_done = 1'b1;
    end else begin
      if (act == ACT_START) begin
        sent_cnt   = '0;
        missed_cnt = '0;
        glitch_cnt = '0;
        tx_phase   = PH_WAIT_FRAME;
      end
      case (tx_phase)
        PH_WAIT_FRAME: begin
          if (tail != ring_head) begin
            byte_idx = '0;
            bit_idx  = '0;
            tx_phase = PH_WAIT_CS_LOW;
          end
        end
        PH_WAIT_CS_LOW: begin
          if (!cs) tx_phase = PH_WAIT_CLK_LOW;
        end
        PH_WAIT_CLK_LOW: begin
          if (cs) begin
            glitch_cnt = glitch_cnt + CNT_W'(1);
            tx_phase   = PH_WAIT_CS_LOW;
          end else if (!sck) begin
            tx_phase = PH_WAIT_CLK_HIGH;
          end
        end
        PH_WAIT_CLK_HIGH: begin
          if (cs) begin
            tx_phase = PH_WAIT_CS_LOW;
          end else if (sck) begin
            miso_bit = data[bit_idx];
            tx_phase = PH_WAIT_CLK_LOW;
            if (bit_idx == BIT_W'(BITS_PER_BYTE - 1)) begin
              bit_idx = '0;
              if (byte_idx == LAST_BYTE) begin
                sent_cnt     = sent_cnt + CNT_W'(1);
                r.frame_done = 1'b1;
                ring_head    = ring_head + HEAD_W'(1);
                byte_idx     = '0;
                // underrun: park until software queues another frame
                if (tail == ring_head) begin
                  missed_cnt = missed_cnt + CNT_W'(1);
                  tx_phase   = PH_WAIT_FRAME;
                end
              end else begin
                byte_idx = byte_idx + OFFSET_W'(1);
              end
            end else begin
              bit_idx = bit_idx + BIT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
    r.miso     = miso_bit;
    r.slot     = ring_head[SLOT_W-1:0];
    r.offset   = byte_idx;
    r.mode     = tx_phase;
    r.sent     = sent_cnt;
    r.missed   = missed_cnt;
    r.glitches = glitch_cnt;
    return r;
  endfunction

  // hold the beat until accepted, then queue its predicted result
  task automatic offer_beat(
      input logic [ACTION_W-1:0]      act,
      input logic                     cs,
      input logic                     sck,
      input logic [HEAD_W-1:0]        tail,
      input logic [BITS_PER_BYTE-1:0] data);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= IN_DATA_W'({data, tail, sck, cs});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_status.push_back(advance_transmitter(act, cs, sck, tail, data));
  endtask

  task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic test_stopped_pins();
    offer_beat(ACT_SAMPLE, 1'b0, 1'b0, HEAD_W'(3), 8'hA5);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, HEAD_W'(3), 8'h5A);
    offer_beat(ACT_UNUSED, 1'b1, 1'b1, HEAD_W'(7), 8'hFF);
  endtask

  task automatic test_start_stop();
    // empty ring: start parks in wait frame until the tail moves
    offer_beat(ACT_START, 1'b0, 1'b0, ring_head, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, ring_head, 8'h11);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b0, ring_head + HEAD_W'(3), 8'h22);
    offer_beat(ACT_STOP, 1'b0, 1'b0, ring_head + HEAD_W'(3), 8'h33);
    // waiting frame opens on the start beat itself
    offer_beat(ACT_START, 1'b1, 1'b0, ring_head + HEAD_W'(1), 8'h44);
  endtask

  task automatic test_cs_and_bits();
    logic [HEAD_W-1:0] tail;
    tail = ring_head + HEAD_W'(1);
    offer_beat(ACT_SAMPLE, 1'b1, 1'b0, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'h00);
    // chip select drops out while waiting for clock low
    offer_beat(ACT_SAMPLE, 1'b1, 1'b1, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b0, tail, 8'h00);
    // chip select drops out while waiting for clock high: no count
    offer_beat(ACT_SAMPLE, 1'b1, 1'b1, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b0, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b0, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'hFF);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b0, tail, 8'hFF);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'h00);
    offer_beat(ACT_UNUSED, 1'b0, 1'b0, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'h04);
    offer_beat(ACT_START, 1'b0, 1'b0, tail, 8'h00);
  endtask

  task automatic test_frame_transfer();
    logic [HEAD_W-1:0] tail;
    idle_on = 1'b0;
    tail = ring_head + HEAD_W'(2);
    offer_beat(ACT_START, 1'b0, 1'b0, tail, 8'h00);
    offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'h00);
    // whole bytes back to back, crossing several byte boundaries
    for (int n = 0; n < STREAM_BITS; n++) begin
      offer_beat(ACT_SAMPLE, 1'b0, 1'b0, tail, 8'($urandom));
      offer_beat(ACT_SAMPLE, 1'b0, 1'b1, tail, 8'($urandom));
    end
    offer_beat(ACT_SAMPLE, 1'b0, 1'b0, ring_head + HEAD_W'(1), 8'h00);
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_left = 300;
    for (int n = 0; n < 40; n++)
      offer_beat(ACT_SAMPLE, 1'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned r;
    logic [ACTION_W-1:0] act;
    logic cs;
    logic sck;
    logic sck_now;
    logic [HEAD_W-1:0] tail;
    tail = ring_head + HEAD_W'(1);
    sck_now = 1'b0;
    offer_beat(ACT_START, 1'b0, 1'b0, tail, 8'($urandom));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 199);
      act = ACT_SAMPLE;
      cs  = 1'($urandom);
      sck = 1'($urandom);
      if (r < 6) begin
        act = ACT_START;
      end else if (r < 8) begin
        act = ACT_STOP;
      end else if (r < 12) begin
        act = ACT_UNUSED;
      end else if (r >= 22) begin
        // well-formed clocking with chip select held low
        if (r >= 30) sck_now = ~sck_now;
        cs  = 1'b0;
        sck = sck_now;
      end
      if ($urandom_range(0, 19) == 0) tail = 3'($urandom);
      offer_beat(act, cs, sck, tail, 8'($urandom));
    end
  endtask

  // receiver: random stalls plus the long hold-off requested by a test
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        m_tready <= (stall_left == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    tx_status_t got;
    tx_status_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata[STATUS_W-1:0]};
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          compare_field("miso", want.miso, got.miso);
          compare_field("read_slot", want.slot, got.slot);
          compare_field("read_offset", want.offset, got.offset);
          compare_field("mode", want.mode, got.mode);
          compare_field("frames_sent", want.sent, got.sent);
          compare_field("frames_missed", want.missed, got.missed);
          compare_field("cs_glitches", want.glitches, got.glitches);
          compare_field("stop_done", want.stop_done, got.stop_done);
          compare_field("frame_done", want.frame_done, got.frame_done);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= ACT_SAMPLE;
    s_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_stopped_pins();
    test_start_stop();
    test_cs_and_bits();
    test_frame_transfer();
    test_backpressure();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sft_pkg.sv
rtl/sft_step.sv
rtl/spi_slave_frame_transmitter.sv
tb/sv/spi_slave_frame_transmitter_test.sv
